FILE: sv/weighted_lottery_with_use_limits_core_defines.svh
// Assertion macros for the weighted lottery core.
`ifndef WEIGHTED_LOTTERY_WITH_USE_LIMITS_CORE_DEFINES_SVH
`define WEIGHTED_LOTTERY_WITH_USE_LIMITS_CORE_DEFINES_SVH

// same-cycle implication
`define WLUL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wlul: same-cycle check failed");

// next-cycle implication
`define WLUL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wlul: next-cycle check failed");

`endif

FILE: sv/wlul_pkg.sv
// Package: sizes, codes and word types of the weighted lottery core.
package wlul_pkg;

  localparam int ENTRIES     = 16;
  localparam int WEIGHT_BITS = 12;
  localparam int VALUE_BITS  = 10;
  localparam int DRAW_BITS   = 16;
  localparam int LIMIT_BITS  = 8;
  localparam int TOTAL_BITS  = 16;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int CNT_W       = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_PICK    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_PICKED    = 2'd0,
    STAT_DEFAULT   = 2'd1,
    STAT_EXHAUSTED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_SUM,
    ST_RESULT
  } state_t;

  typedef struct packed {
    action_t                action;
    logic [VALUE_BITS-1:0]  entry_value;
    logic [WEIGHT_BITS-1:0] entry_weight;
    logic [LIMIT_BITS-1:0]  entry_limit;
    logic [DRAW_BITS-1:0]   draw;
  } in_word_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] chosen_value;
    status_t               status;
    logic [TOTAL_BITS-1:0] remaining_weight;
  } out_word_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0]  value;
    logic [WEIGHT_BITS-1:0] weight;
    logic [LIMIT_BITS-1:0]  limit;
  } base_t;

  typedef struct packed {
    logic                   valid;
    logic [VALUE_BITS-1:0]  value;
    logic [WEIGHT_BITS-1:0] weight;
    logic [LIMIT_BITS-1:0]  uses;
  } live_t;

  typedef struct packed {
    logic             append;
    logic             copy;
    logic             rot_base;
    logic             rot_live;
    logic [CNT_W-1:0] load_count;
    base_t            wdata;
  } cell_ctl_t;

endpackage

FILE: sv/weighted_lottery_with_use_limits_core.sv
// Top level: weighted lottery with use limits over a ring of entry cells.
//
//  channel | signals                        | word       | moves
//  in      | in_valid, in_ready, in_data    | in_word_t  | action and entry or draw
//  out     | out_valid, out_ready, out_data | out_word_t | one word per pick
//
// Clear and append return straight to idle. A restart turns the loaded ring once
// to sum the weights. A pick turns the working ring once past the head comparator
// and then enters its result state; with nothing loaded or a zero total it goes
// straight to the result state. Reset empties both tables; no clearing pass.
// A stalled output holds the core in its result state; ready only in idle.
`include "weighted_lottery_with_use_limits_core_defines.svh"

module weighted_lottery_with_use_limits_core import wlul_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  state_t                state, state_next;
  logic [CNT_W-1:0]      loaded_count;
  logic [TOTAL_BITS-1:0] total;
  logic [TOTAL_BITS-1:0] rem;
  logic [IDX_W-1:0]      step;
  logic                  found;
  logic [VALUE_BITS-1:0] res_value;
  status_t               res_status;

  cell_ctl_t ctl;
  base_t     base_q   [ENTRIES];
  live_t     live_q   [ENTRIES];
  base_t     base_nb  [ENTRIES];
  live_t     live_nb  [ENTRIES];
  live_t     head_next;

  logic                          accept;
  logic                          out_free;
  logic                          last_step;
  logic                          hit;
  logic [LIMIT_BITS-1:0]         uses_dec;
  logic [TOTAL_BITS-1:0]         head_w;
  logic [TOTAL_BITS:0]           sum_wide;
  logic [DRAW_BITS+TOTAL_BITS-1:0] product;

  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign last_step = (step == IDX_W'(ENTRIES - 1));
  assign head_w    = TOTAL_BITS'(live_q[0].weight);
  assign product   = (DRAW_BITS + TOTAL_BITS)'(in_data.draw)
                     * (DRAW_BITS + TOTAL_BITS)'(total);
  assign sum_wide  = (TOTAL_BITS + 1)'(total) + (TOTAL_BITS + 1)'(base_q[0].weight);

  // head comparator: the entry whose weight covers what is left of the draw
  assign hit      = !found && live_q[0].valid && (rem < head_w);
  assign uses_dec = live_q[0].uses - LIMIT_BITS'(1);

  always_comb begin
    head_next = live_q[0];
    if (hit && (live_q[0].uses != '0)) begin
      head_next.uses = uses_dec;
      if (uses_dec == '0) begin
        head_next.valid = 1'b0;
      end
    end
  end

  // ring: cell i takes from cell i+1; the last cell takes base cell 0 and the updated live head
  for (genvar i = 0; i < ENTRIES; i++) begin : g_ring
    assign base_nb[i] = base_q[(i + 1) % ENTRIES];
    if (i == ENTRIES - 1) begin : g_tail
      assign live_nb[i] = head_next;
    end else begin : g_mid
      assign live_nb[i] = live_q[i + 1];
    end
    wlul_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .slot    (IDX_W'(i)),
      .ctl     (ctl),
      .base_in (base_nb[i]),
      .live_in (live_nb[i]),
      .base_q  (base_q[i]),
      .live_q  (live_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.action)
            ACT_RESTART: state_next = ST_SUM;
            ACT_PICK: begin
              if ((loaded_count == '0) || (total == '0)) begin
                state_next = ST_RESULT;
              end else begin
                state_next = ST_WALK;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_WALK:   if (last_step) state_next = ST_RESULT;
      ST_SUM:    if (last_step) state_next = ST_IDLE;
      ST_RESULT: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state == ST_IDLE);
    ctl.append     = accept && (in_data.action == ACT_APPEND)
                     && (loaded_count < CNT_W'(ENTRIES));
    ctl.copy       = accept && (in_data.action == ACT_RESTART);
    ctl.rot_base   = (state == ST_SUM);
    ctl.rot_live   = (state == ST_WALK);
    ctl.load_count = loaded_count;
    ctl.wdata.value  = in_data.entry_value;
    ctl.wdata.weight = in_data.entry_weight;
    ctl.wdata.limit  = in_data.entry_limit;
  end

  // control counters and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
      total        <= '0;
      found        <= 1'b0;
      step         <= '0;
    end else begin
      if (accept) begin
        step  <= '0;
        found <= 1'b0;
        case (in_data.action)
          ACT_CLEAR:   loaded_count <= '0;
          ACT_APPEND:  if (ctl.append) loaded_count <= loaded_count + CNT_W'(1);
          ACT_RESTART: total <= '0;
          default:     ;
        endcase
      end else if (state == ST_SUM) begin
        step <= step + IDX_W'(1);
        if (CNT_W'(step) < loaded_count) begin
          total <= sum_wide[TOTAL_BITS] ? '1 : sum_wide[TOTAL_BITS-1:0];
        end
      end else if (state == ST_WALK) begin
        step <= step + IDX_W'(1);
        if (hit) begin
          found <= 1'b1;
          if ((live_q[0].uses != '0) && (uses_dec == '0)) begin
            total <= (total > head_w) ? total - head_w : '0;
          end
        end
      end
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      rem        <= product[DRAW_BITS +: TOTAL_BITS];
      res_value  <= '0;
      res_status <= (loaded_count == '0) ? STAT_DEFAULT : STAT_EXHAUSTED;
    end else if (state == ST_WALK) begin
      if (hit) begin
        res_value  <= live_q[0].value;
        res_status <= STAT_PICKED;
      end else if (!found && live_q[0].valid) begin
        rem <= rem - head_w;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_RESULT) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_RESULT) && out_free) begin
      out_data.chosen_value     <= res_value;
      out_data.status           <= res_status;
      out_data.remaining_weight <= total;
    end
  end

  `WLUL_ASSERT_NEXT(a_result_sent, clk, rst, (state == ST_RESULT) && out_free, out_valid)
  `WLUL_ASSERT_NEXT(a_walk_total_falls, clk, rst, state == ST_WALK, total <= $past(total))
  `WLUL_ASSERT_NOW(a_value_zero_unless_picked, clk, rst,
    out_valid && (out_data.status != STAT_PICKED), out_data.chosen_value == '0)
  `WLUL_ASSERT_NOW(a_loaded_bound, clk, rst, 1'b1, loaded_count <= CNT_W'(ENTRIES))

endmodule

FILE: sv/wlul_cell.sv
// One ring cell: a loaded entry and its working copy, passed on to the neighbor.
module wlul_cell import wlul_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] slot,
  input  cell_ctl_t        ctl,
  input  base_t            base_in,
  input  live_t            live_in,
  output base_t            base_q,
  output live_t            live_q
);

  logic [CNT_W-1:0] slot_ext;
  logic             wr_hit;

  assign slot_ext = CNT_W'(slot);
  assign wr_hit   = ctl.append && (slot_ext == ctl.load_count);

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      base_q <= ctl.wdata;
    end else if (ctl.rot_base) begin
      base_q <= base_in;
    end
  end

  // only the valid bit needs a reset; the payload is don't-care while invalid
  always_ff @(posedge clk) begin
    if (rst) begin
      live_q.valid <= 1'b0;
    end else if (ctl.copy) begin
      live_q.valid  <= (slot_ext < ctl.load_count);
      live_q.value  <= base_q.value;
      live_q.weight <= base_q.weight;
      live_q.uses   <= base_q.limit;
    end else if (ctl.rot_live) begin
      live_q <= live_in;
    end
  end

endmodule

FILE: test/wlul_pick_checker.sv
// Lottery checker: mirrors the entry tables, predicts each pick word and compares it.
module wlul_pick_checker import wlul_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_word_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_word_t   out_data,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  localparam int REPORT_LIMIT = 10;
  localparam int TOTAL_MAX    = (1 << TOTAL_BITS) - 1;

  base_t       loaded_tbl [ENTRIES];
  base_t       live_tbl [ENTRIES];  // limit field counts uses left
  int          n_loaded;
  int          n_live;
  int unsigned total;
  out_word_t   due_picks [$];
  int unsigned bad = 0;
  bit          has_pick;
  out_word_t   fresh;
  out_word_t   want;

  function automatic void play_word(input in_word_t w, output bit produced,
                                    output out_word_t r);
    int          sum;
    longint      idx;
    bit          found;
    produced = 1'b0;
    r = '0;
    r.status = STAT_EXHAUSTED;
    found = 1'b0;
    case (w.action)
      ACT_CLEAR: n_loaded = 0;
      ACT_APPEND: begin
        if (n_loaded < ENTRIES) begin
          loaded_tbl[n_loaded] = '{value: w.entry_value, weight: w.entry_weight,
                                   limit: w.entry_limit};
          n_loaded++;
        end
      end
      ACT_RESTART: begin
        sum = 0;
        for (int i = 0; i < n_loaded; i++) begin
          live_tbl[i] = loaded_tbl[i];
          sum += loaded_tbl[i].weight;
          if (sum > TOTAL_MAX) sum = TOTAL_MAX;
        end
        n_live = n_loaded;
        total = sum;
      end
      ACT_PICK: begin
        produced = 1'b1;
        if (n_loaded == 0) begin
          r.status = STAT_DEFAULT;
        end else if (total != 0) begin
          idx = (longint'(w.draw) * longint'(total)) >> DRAW_BITS;
          for (int i = 0; i < n_live && !found; i++) begin
            if (idx < live_tbl[i].weight) begin
              found = 1'b1;
              r.chosen_value = live_tbl[i].value;
              r.status = STAT_PICKED;
              if (live_tbl[i].limit != 0) begin
                live_tbl[i].limit = live_tbl[i].limit - 1'b1;
                if (live_tbl[i].limit == 0) begin
                  // used up: weight leaves the total, later entries slide down
                  total = (total > live_tbl[i].weight) ? total - live_tbl[i].weight : 0;
                  for (int j = i; j + 1 < n_live; j++) live_tbl[j] = live_tbl[j + 1];
                  n_live--;
                end
              end
            end else begin
              idx -= live_tbl[i].weight;
            end
          end
        end
        r.remaining_weight = TOTAL_BITS'(total);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      n_loaded = 0;
      n_live = 0;
      total = 0;
      due_picks.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_picks.size() == 0) begin
          bad++;
          if (bad <= REPORT_LIMIT)
            $display("pick word with none pending: value %0d status %0d weight %0d",
                     out_data.chosen_value, out_data.status, out_data.remaining_weight);
        end else begin
          want = due_picks.pop_front();
          if (out_data.chosen_value !== want.chosen_value ||
              out_data.status !== want.status ||
              out_data.remaining_weight !== want.remaining_weight) begin
            bad++;
            if (bad <= REPORT_LIMIT)
              $display({"pick word wrong: expected value %0d status %0d weight %0d,",
                        " got value %0d status %0d weight %0d"},
                       want.chosen_value, want.status, want.remaining_weight,
                       out_data.chosen_value, out_data.status, out_data.remaining_weight);
          end
        end
      end
      if (in_valid && in_ready) begin
        play_word(in_data, has_pick, fresh);
        if (has_pick) due_picks.insert(due_picks.size(), fresh);
      end
    end
    mismatches  <= bad;
    outstanding <= due_picks.size();
  end

endmodule

FILE: test/weighted_lottery_with_use_limits_core_tb.sv
// Testbench top: drives table loads, restarts and picks into the lottery core.
module weighted_lottery_with_use_limits_core_tb;
  import wlul_pkg::*;

  localparam int ITEM_GOAL     = 1850;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int VALUE_MAX     = (1 << VALUE_BITS) - 1;
  localparam int WEIGHT_MAX    = (1 << WEIGHT_BITS) - 1;
  localparam int LIMIT_MAX     = (1 << LIMIT_BITS) - 1;
  localparam int DRAW_MAX      = (1 << DRAW_BITS) - 1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned sent = 0;
  bit          burst = 1'b0;
  int          ready_hold = 0;
  int          ready_roll;
  int          cycle_cnt = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  weighted_lottery_with_use_limits_core uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  wlul_pick_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // receiver: short stalls mostly, a few long ones, and long open stretches
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 45) begin
        out_ready <= 1'b1;
        ready_hold = $urandom_range(0, 15);
      end else if (ready_roll < 80) begin
        out_ready <= 1'b0;
        ready_hold = $urandom_range(0, 2);
      end else if (ready_roll < 92) begin
        out_ready <= 1'b0;
        ready_hold = $urandom_range(8, 40);
      end else begin
        out_ready <= 1'b1;
        ready_hold = $urandom_range(60, 200);
      end
    end
  end

  function automatic in_word_t mk_word(input action_t a);
    in_word_t w;
    w.action       = a;
    w.entry_value  = VALUE_BITS'($urandom_range(0, VALUE_MAX));
    w.entry_weight = WEIGHT_BITS'($urandom_range(0, WEIGHT_MAX));
    w.entry_limit  = LIMIT_BITS'($urandom_range(0, LIMIT_MAX));
    w.draw         = DRAW_BITS'($urandom_range(0, DRAW_MAX));
    return w;
  endfunction

  task automatic rest(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // holds the word until taken, then maybe leaves a gap
  task automatic send(input in_word_t w, input bit counts);
    int r;
    int g;
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (counts) sent++;
    r = $urandom_range(0, 99);
    if (burst || r < 55) g = 0;
    else if (r < 90) g = $urandom_range(1, 3);
    else g = $urandom_range(8, 40);
    if (g > 0) rest(g);
  endtask

  task automatic drain();
    rest(0);
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    in_word_t w;
    int       n;
    int       kind;
    int       r;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // nothing loaded yet: default
    send(mk_word(ACT_PICK), 1'b1);
    // fill past full; the last append is dropped
    for (int i = 0; i <= ENTRIES; i++) begin
      w = mk_word(ACT_APPEND);
      if (i == 0) begin
        w.entry_value  = VALUE_BITS'(VALUE_MAX);
        w.entry_weight = WEIGHT_BITS'(WEIGHT_MAX);
        w.entry_limit  = LIMIT_BITS'(1);
      end else if (i == 1) begin
        w.entry_value = '0; w.entry_weight = '0; w.entry_limit = '0;
      end else if (i == 2) begin
        w.entry_value  = VALUE_BITS'(VALUE_MAX);
        w.entry_weight = WEIGHT_BITS'(WEIGHT_MAX);
        w.entry_limit  = LIMIT_BITS'(LIMIT_MAX);
      end
      send(w, i < ENTRIES);
    end
    // loaded but never restarted: zero total, exhausted
    send(mk_word(ACT_PICK), 1'b1);
    send(mk_word(ACT_RESTART), 1'b1);
    w = mk_word(ACT_PICK);
    w.draw = '0;
    send(w, 1'b1);
    w.draw = DRAW_BITS'(DRAW_MAX);
    send(w, 1'b1);
    send(mk_word(ACT_CLEAR), 1'b1);
    // working table survives a clear, yet picks report default
    send(mk_word(ACT_PICK), 1'b1);
    drain();

    while (sent < ITEM_GOAL) begin
      kind  = $urandom_range(0, 99);
      burst = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) drain();
      if (kind < 80) begin
        send(mk_word(ACT_CLEAR), 1'b1);
        r = $urandom_range(0, 99);
        if (r < 4) n = 0;
        else if (r < 10) n = $urandom_range(ENTRIES, ENTRIES + 1);
        else n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          w = mk_word(ACT_APPEND);
          r = $urandom_range(0, 99);
          if (r < 15) w.entry_weight = '0;
          else if (r < 30) w.entry_weight = WEIGHT_BITS'(WEIGHT_MAX);
          else if (r < 70) w.entry_weight = WEIGHT_BITS'($urandom_range(1, 15));
          r = $urandom_range(0, 99);
          if (r < 25) w.entry_limit = '0;
          else if (r < 75) w.entry_limit = LIMIT_BITS'($urandom_range(1, 3));
          else if (r < 90) w.entry_limit = LIMIT_BITS'($urandom_range(4, 20));
          else w.entry_limit = LIMIT_BITS'($urandom_range(200, LIMIT_MAX));
          send(w, i < ENTRIES);
        end
      end
      if (kind < 92) begin
        send(mk_word(ACT_RESTART), 1'b1);
        n = $urandom_range(1, 24);
        for (int i = 0; i < n; i++) begin
          w = mk_word(ACT_PICK);
          r = $urandom_range(0, 99);
          if (r < 10) w.draw = '0;
          else if (r < 20) w.draw = DRAW_BITS'(DRAW_MAX);
          send(w, 1'b1);
        end
      end else begin
        // noise: any action, any content
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) send(mk_word(action_t'($urandom_range(0, 3))), 1'b1);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("weighted_lottery_with_use_limits_core: match");
    else
      $display("weighted_lottery_with_use_limits_core: mismatch");
    $finish;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("weighted_lottery_with_use_limits_core: mismatch");
    $finish;
  end

endmodule
